// ===== hdl/lffa_pkg.sv =====
// Shared types, codes and a helper function for the lowest-free frame allocator.
`default_nettype none

package lffa_pkg;

  // Request codes carried in the action field.
  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE  = 2'd1;
  localparam logic [1:0] ACT_FIND  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFREE = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;
  localparam logic [1:0] ST_DOUBLE = 2'd3;

  localparam int FRAME_SHIFT = 12;
  localparam int FIDX_W      = 32 - FRAME_SHIFT;
  localparam int WORD_W      = 64;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic accept;
    logic step2;
    logic step1;
    logic step0;
    logic update;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic out_busy;
  } stat_t;

  // Index of the lowest set bit of a 64-bit word, found by halving the word
  // six times. Returns 63 for an all-zero word.
  function automatic logic [5:0] ffs64(input logic [63:0] v);
    logic [63:0] w;
    logic [5:0]  r;
    w = v;
    r = '0;
    for (int k = 5; k >= 0; k--) begin
      if ((w & ((64'd1 << (1 << k)) - 64'd1)) == 64'd0) begin
        r[k] = 1'b1;
        w    = w >> (1 << k);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/lffa_ctrl.sv =====
// Controller state machine that sequences the allocator's datapath.
`default_nettype none

module lffa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  input  wire logic          in_alloc,
  output logic               in_tready,
  input  wire lffa_pkg::stat_t stat,
  output lffa_pkg::cmd_t     cmd
);
  import lffa_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_D2    = 6'b000100,
    S_D1    = 6'b001000,
    S_D0    = 6'b010000,
    S_UPD   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = in_alloc ? S_D2 : S_UPD;
        end
      end
      S_D2: begin
        cmd.step2 = 1'b1;
        state_nxt = S_D1;
      end
      S_D1: begin
        cmd.step1 = 1'b1;
        state_nxt = S_D0;
      end
      S_D0: begin
        cmd.step0 = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        // Hold here until the result register can take the new transaction.
        if (!stat.out_busy) begin
          cmd.update = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lffa_dp.sv =====
// Datapath: three-level free-frame bitmap memories, summary register and result register.
`default_nettype none

module lffa_dp #(
  parameter int NUM_FRAMES = 4096
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire lffa_pkg::cmd_t cmd,
  output lffa_pkg::stat_t    stat,
  input  wire logic [1:0]    in_action,
  input  wire logic [31:0]   in_phys_address,
  input  wire logic          out_tready,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [11:0]        out_frame_index,
  output logic [31:0]        out_frame_base,
  output logic               out_frame_used
);
  import lffa_pkg::*;

  // Level 0 holds one free bit per frame, level 1 one bit per level-0 word
  // that has a free frame, level 2 likewise for level 1, and the top
  // register one bit per level-2 word.
  localparam int W0 = (NUM_FRAMES + 63) / 64;
  localparam int W1 = (NUM_FRAMES + 4095) / 4096;
  localparam int W2 = (NUM_FRAMES + 262143) / 262144;
  localparam int A0 = (W0 > 1) ? $clog2(W0) : 1;
  localparam int A1 = (W1 > 1) ? $clog2(W1) : 1;
  localparam int A2 = (W2 > 1) ? $clog2(W2) : 1;
  localparam int D0 = 1 << A0;
  localparam int D1 = 1 << A1;
  localparam int D2 = 1 << A2;
  localparam int T  = D2;
  localparam logic [FIDX_W:0] NF = (FIDX_W + 1)'(NUM_FRAMES);

  logic [WORD_W-1:0] mem0 [D0];
  logic [WORD_W-1:0] mem1 [D1];
  logic [WORD_W-1:0] mem2 [D2];
  logic [WORD_W-1:0] rd0_r, rd1_r, rd2_r;

  logic [T-1:0]      top_r;
  logic [FIDX_W-1:0] idx_r, idx_nxt;
  logic [1:0]        op_r;
  logic              nofree_r, range_r;
  logic [A0-1:0]     clr_cnt_r;

  logic [A2-1:0]     top_sel;
  logic [A0-1:0]     ra0;
  logic [A1-1:0]     ra1;
  logic [A2-1:0]     ra2;

  logic [WORD_W-1:0] oh0, oh1, oh2;
  logic [T-1:0]      oht;
  logic              bit0;
  logic [WORD_W-1:0] a_new0, a_new1, a_new2;
  logic [T-1:0]      a_top;
  logic              wr_en;
  logic [WORD_W-1:0] new0, new1, new2;
  logic [T-1:0]      new_top;
  logic [1:0]        res_status;
  logic [11:0]       res_index;
  logic [31:0]       res_base;
  logic              res_used;

  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [11:0]       out_index_r;
  logic [31:0]       out_base_r;
  logic              out_used_r;

  // Lowest populated level-2 word.
  always_comb begin
    top_sel = '0;
    for (int k = T - 1; k >= 0; k--) begin
      if (top_r[k]) top_sel = A2'(k);
    end
  end

  // The frame index is built one level at a time during an allocation.
  always_comb begin
    idx_nxt = idx_r;
    priority if (cmd.accept) begin
      if (in_action == ACT_ALLOC) begin
        idx_nxt           = '0;
        idx_nxt[18 +: A2] = top_sel;
      end else begin
        idx_nxt = in_phys_address[31:FRAME_SHIFT];
      end
    end else if (cmd.step2) begin
      idx_nxt[17:12] = ffs64(rd2_r);
    end else if (cmd.step1) begin
      idx_nxt[11:6] = ffs64(rd1_r);
    end else if (cmd.step0) begin
      idx_nxt[5:0] = ffs64(rd0_r);
    end else begin
      idx_nxt = idx_r;
    end
  end

  assign ra0 = idx_nxt[6 +: A0];
  assign ra1 = idx_nxt[12 +: A1];
  assign ra2 = idx_nxt[18 +: A2];

  always_comb begin
    oh0  = 64'd1 << idx_r[5:0];
    oh1  = 64'd1 << idx_r[11:6];
    oh2  = 64'd1 << idx_r[17:12];
    oht  = T'(1) << idx_r[18 +: A2];
    bit0 = rd0_r[idx_r[5:0]];

    // Taking a frame clears summary bits only where a whole word empties.
    a_new0 = rd0_r & ~oh0;
    a_new1 = (a_new0 == '0) ? (rd1_r & ~oh1) : rd1_r;
    a_new2 = (a_new1 == '0) ? (rd2_r & ~oh2) : rd2_r;
    a_top  = (a_new2 == '0) ? (top_r & ~oht) : top_r;

    wr_en      = 1'b0;
    new0       = a_new0;
    new1       = a_new1;
    new2       = a_new2;
    new_top    = a_top;
    res_status = ST_OK;
    res_index  = idx_r[11:0];
    res_base   = {idx_r, 12'd0};
    res_used   = 1'b0;

    priority if (op_r == ACT_ALLOC) begin
      if (nofree_r) begin
        res_status = ST_NOFREE;
        res_index  = '0;
        res_base   = '0;
      end else begin
        wr_en    = 1'b1;
        res_used = 1'b1;
      end
    end else if (range_r) begin
      res_status = ST_RANGE;
      res_index  = '0;
      res_base   = '0;
    end else if (op_r == ACT_FREE) begin
      if (bit0) begin
        res_status = ST_DOUBLE;
      end else begin
        wr_en   = 1'b1;
        new0    = rd0_r | oh0;
        new1    = rd1_r | oh1;
        new2    = rd2_r | oh2;
        new_top = top_r | oht;
      end
    end else begin
      res_used = !bit0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem0[clr_cnt_r]         <= '0;
      mem1[clr_cnt_r[A1-1:0]] <= '0;
      mem2[clr_cnt_r[A2-1:0]] <= '0;
    end else if (cmd.update && wr_en) begin
      mem0[idx_r[6 +: A0]]  <= new0;
      mem1[idx_r[12 +: A1]] <= new1;
      mem2[idx_r[18 +: A2]] <= new2;
    end
    rd0_r <= mem0[ra0];
    rd1_r <= mem1[ra1];
    rd2_r <= mem2[ra2];
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.accept) begin
      op_r     <= in_action;
      nofree_r <= (top_r == '0);
      range_r  <= ({1'b0, in_phys_address[31:FRAME_SHIFT]} >= NF);
    end
    if (cmd.update) begin
      out_status_r <= res_status;
      out_index_r  <= res_index;
      out_base_r   <= res_base;
      out_used_r   <= res_used;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r       <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) clr_cnt_r <= clr_cnt_r + A0'(1);
      if (cmd.update && wr_en) top_r <= new_top;
      if (cmd.update) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.clear_done = (clr_cnt_r == '1);
  assign stat.out_busy   = out_valid_r && !out_tready;

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_frame_index = out_index_r;
  assign out_frame_base  = out_base_r;
  assign out_frame_used  = out_used_r;

endmodule

`default_nettype wire

// ===== hdl/lowest_free_frame_allocator_unit.sv =====
// Top level of the lowest-free frame allocator with its stream ports.
`default_nettype none

// Tracks NUM_FRAMES physical 4 KiB frames, all in use after reset. Action 0
// allocates the lowest free frame, 1 frees the frame holding phys_address,
// 2 (and 3) reports that frame's index, base and use mark; each request
// returns exactly one result transaction. Free state lives in a three-level
// bitmap (frames, then 64-frame words, then 4096-frame words) plus a small
// top register. A free or find goes from idle straight to the update state;
// an allocate first passes the D2, D1 and D0 states, one registered memory
// read per bitmap level on the way down. The result sits in an output
// register, and a new request is taken while it waits. After reset the block
// clears every bitmap memory address in turn before taking requests.
module lowest_free_frame_allocator_unit #(
  parameter int NUM_FRAMES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [1:0] action, [33:2] phys_address, [39:34] zero
  input  wire logic [39:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [1:0] status, [13:2] frame_index, [45:14] frame_base, [46] frame_used, [47] zero
  output logic [47:0]      out_tdata
);
  import lffa_pkg::*;

  cmd_t        cmd;
  stat_t       stat;
  logic [1:0]  status;
  logic [11:0] frame_index;
  logic [31:0] frame_base;
  logic        frame_used;

  lffa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_alloc  (in_tdata[1:0] == ACT_ALLOC),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lffa_dp #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_action       (in_tdata[1:0]),
    .in_phys_address (in_tdata[33:2]),
    .out_tready      (out_tready),
    .out_valid       (out_tvalid),
    .out_status      (status),
    .out_frame_index (frame_index),
    .out_frame_base  (frame_base),
    .out_frame_used  (frame_used)
  );

  assign out_tdata = {1'b0, frame_used, frame_base, frame_index, status};

endmodule

`default_nettype wire

// ===== tb/tb_lowest_free_frame_allocator_unit.sv =====
// Self-checking testbench for the lowest-free frame allocator unit.
`timescale 1ns / 1ps

module tb_lowest_free_frame_allocator_unit;
  import lffa_pkg::*;

  localparam int NUM_FRAMES   = 4096;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 1350;
  localparam int NUM_PHASES   = 4;

  typedef struct {
    logic [1:0]  action;
    logic [31:0] addr;
    bit          hold_until_empty;
    int          phase;
  } frame_req_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;

  frame_req_t  pending_reqs[$];
  logic [47:0] expected_results[$];
  logic        frame_in_use[NUM_FRAMES] = '{default: 1'b1};
  int          sender_idle_pct[NUM_PHASES] = '{0, 81, 0, 28};
  int          receiver_stall_pct[NUM_PHASES] = '{0, 0, 81, 28};
  int          cur_phase = 0;
  int          error_count = 0;
  int          cycle_count = 0;

  lowest_free_frame_allocator_unit #(
    .NUM_FRAMES(NUM_FRAMES)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [47:0] pack_frame_result(logic [1:0] status, logic [11:0] idx,
                                                    logic used);
    logic [31:0] base;
    base = {8'd0, idx, 12'd0};
    return {1'b0, used, base, idx, status};
  endfunction

  // Applies one request to the testbench copy of the use map and returns
  // the result the block must produce for it.
  function automatic logic [47:0] predict_frame_result(logic [1:0] action, logic [31:0] addr);
    logic [19:0] idx;
    idx = addr[31:FRAME_SHIFT];
    if (action == ACT_ALLOC) begin
      for (int i = 0; i < NUM_FRAMES; i++) begin
        if (!frame_in_use[i]) begin
          frame_in_use[i] = 1'b1;
          return pack_frame_result(ST_OK, i[11:0], 1'b1);
        end
      end
      return pack_frame_result(ST_NOFREE, 12'd0, 1'b0);
    end
    if (idx >= NUM_FRAMES) begin
      return pack_frame_result(ST_RANGE, 12'd0, 1'b0);
    end
    if (action == ACT_FREE) begin
      if (!frame_in_use[idx]) begin
        return pack_frame_result(ST_DOUBLE, idx[11:0], 1'b0);
      end
      frame_in_use[idx] = 1'b0;
      return pack_frame_result(ST_OK, idx[11:0], 1'b0);
    end
    // Action 3 behaves as a find.
    return pack_frame_result(ST_OK, idx[11:0], frame_in_use[idx]);
  endfunction

  task automatic queue_req(logic [1:0] action, logic [31:0] addr, bit hold, int phase);
    frame_req_t r;
    r.action = action;
    r.addr = addr;
    r.hold_until_empty = hold;
    r.phase = phase;
    pending_reqs.push_back(r);
  endtask

  // Mostly in-range traffic so that allocations walk deep into the map; a
  // tenth of the requests carry out-of-range addresses.
  task automatic queue_random_req(bit hold, int phase);
    int          pick;
    logic [1:0]  action;
    logic [31:0] addr;
    logic [11:0] idx;
    pick = $urandom_range(0, 99);
    addr = $urandom;
    idx = ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, NUM_FRAMES - 1))
                                      : 12'($urandom_range(0, 191));
    if (pick < 38) begin
      action = ACT_ALLOC;
    end else if (pick < 72) begin
      action = ACT_FREE;
      addr = {8'd0, idx, addr[11:0]};
    end else if (pick < 90) begin
      action = ($urandom_range(0, 7) == 0) ? 2'd3 : ACT_FIND;
      addr = {8'd0, idx, addr[11:0]};
    end else begin
      action = ($urandom_range(0, 1) == 0) ? ACT_FREE : ACT_FIND;
      if (addr[31:24] == 8'd0) begin
        addr[24 + $urandom_range(0, 7)] = 1'b1;
      end
    end
    queue_req(action, addr, hold, phase);
  endtask

  // Driver: holds each transaction until accepted, predicts at acceptance.
  always @(posedge clk) begin : driver
    frame_req_t nxt;
    bit         holding;
    bit         present;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      holding = in_tvalid && !in_tready;
      present = 1'b0;
      if (in_tvalid && in_tready) begin
        expected_results.push_back(predict_frame_result(in_tdata[1:0], in_tdata[33:2]));
      end
      if (!holding && pending_reqs.size() > 0) begin
        nxt = pending_reqs[0];
        if (nxt.hold_until_empty && (expected_results.size() != 0 || out_tvalid)) begin
          present = 1'b0;
        end else if (nxt.hold_until_empty) begin
          present = 1'b1;
        end else begin
          present = ($urandom_range(0, 99) >= sender_idle_pct[nxt.phase]);
        end
        if (present) begin
          void'(pending_reqs.pop_front());
          cur_phase <= nxt.phase;
          in_tdata  <= {6'd0, nxt.addr, nxt.action};
        end
      end
      if (!holding) begin
        in_tvalid <= present;
      end
    end
  end

  // Monitor: compares each result transaction with the oldest prediction.
  always @(posedge clk) begin : monitor
    logic [47:0] want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transaction %h", $realtime, out_tdata);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[1:0] !== want[1:0]) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $realtime, want[1:0], out_tdata[1:0]);
            error_count++;
          end
          if (out_tdata[13:2] !== want[13:2]) begin
            $display("%0t: frame_index mismatch, expected %0d actual %0d",
                     $realtime, want[13:2], out_tdata[13:2]);
            error_count++;
          end
          if (out_tdata[45:14] !== want[45:14]) begin
            $display("%0t: frame_base mismatch, expected %h actual %h",
                     $realtime, want[45:14], out_tdata[45:14]);
            error_count++;
          end
          if (out_tdata[46] !== want[46]) begin
            $display("%0t: frame_used mismatch, expected %0d actual %0d",
                     $realtime, want[46], out_tdata[46]);
            error_count++;
          end
        end
      end
      out_tready <= ($urandom_range(0, 99) >= receiver_stall_pct[cur_phase]);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;

    // Directed part: empty map, both ends of the address range, double free,
    // out-of-range addresses, the unused action code and the ignored address.
    queue_req(ACT_ALLOC, 32'h0000_0000, 1'b0, 0);
    queue_req(ACT_FIND,  32'h0000_0000, 1'b0, 0);
    queue_req(ACT_FIND,  32'h00FF_FFFF, 1'b0, 0);
    queue_req(ACT_FREE,  32'h0000_0ABC, 1'b0, 0);
    queue_req(ACT_FREE,  32'h0000_0123, 1'b0, 0);
    queue_req(ACT_FREE,  32'h00FF_F000, 1'b0, 0);
    queue_req(2'd3,      32'h00FF_FFFF, 1'b0, 0);
    queue_req(ACT_FREE,  32'h0100_0000, 1'b0, 0);
    queue_req(ACT_FIND,  32'hFFFF_FFFF, 1'b0, 0);
    queue_req(ACT_FREE,  32'hFFFF_FFFF, 1'b0, 0);
    queue_req(ACT_ALLOC, 32'hFFFF_FFFF, 1'b0, 0);
    queue_req(ACT_ALLOC, 32'h0000_0000, 1'b0, 0);
    queue_req(ACT_ALLOC, 32'h0000_0000, 1'b0, 0);
    queue_req(2'd3,      32'h0000_0000, 1'b0, 0);
    queue_req(ACT_FREE,  32'h0080_0FFF, 1'b0, 0);
    queue_req(ACT_FREE,  32'h0003_F000, 1'b0, 0);
    queue_req(ACT_FREE,  32'h0004_0000, 1'b0, 0);
    queue_req(ACT_ALLOC, 32'h0000_0000, 1'b0, 0);
    queue_req(ACT_ALLOC, 32'h0000_0000, 1'b0, 0);
    queue_req(ACT_ALLOC, 32'h0000_0000, 1'b0, 0);
    queue_req(ACT_FIND,  32'h0080_0000, 1'b0, 0);

    // Each phase opens by letting the block run completely dry.
    for (int p = 0; p < NUM_PHASES; p++) begin
      for (int n = 0; n < RANDOM_ITEMS / NUM_PHASES; n++) begin
        queue_random_req(n == 0, p);
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk); while (pending_reqs.size() != 0 || in_tvalid);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/lffa_pkg.sv
hdl/lffa_ctrl.sv
hdl/lffa_dp.sv
hdl/lowest_free_frame_allocator_unit.sv
tb/tb_lowest_free_frame_allocator_unit.sv
